// File: src/tvp_pkg.sv
`default_nettype none

package tvp_pkg;

    // Field and datapath widths.
    localparam int COORD_W   = 32;
    localparam int CLIP_W    = 50;
    localparam int WIDE_W    = 64;
    localparam int DIVN_W    = 68;
    localparam int DIVD_W    = 50;
    localparam int QUO_W     = 16;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 8;
    localparam int IN_W      = 288;
    localparam int OUT_W     = 152;

    // Lane depth: four front stages plus one divider stage per quotient bit.
    localparam int LANE_LAT = 4 + QUO_W;

    // Reject reason codes.
    localparam logic [1:0] REASON_OK    = 2'd0;
    localparam logic [1:0] REASON_NEAR  = 2'd1;
    localparam logic [1:0] REASON_GUARD = 2'd2;

    // Clip w of 1.0 in s.16.
    localparam logic signed [CLIP_W-1:0] W_ONE = CLIP_W'(65536);

    // Matrix registers, two coefficients per register.
    typedef logic [NUM_REGS-1:0][63:0] t_mat;

    // Per vertex status carried beside the dividers.
    typedef struct packed {
        logic near;
        logic guard;
        logic dz_zero;
        logic dz_sat;
    } t_lane_flags;

    // Per vertex result.
    typedef struct packed {
        logic [1:0]        reason;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [15:0]       depth;
    } t_vtx_res;

endpackage

`default_nettype wire

// File: src/tvp_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Requires i_num < i_den * 2**QUO_W.
module tvp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [tvp_pkg::DIVN_W-1:0]  i_num,
    input  wire logic [tvp_pkg::DIVD_W-1:0]  i_den,
    output logic      [tvp_pkg::QUO_W-1:0]   o_quo
);
    import tvp_pkg::*;

    logic [DIVN_W-1:0] r_rem [QUO_W];
    logic [DIVD_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++) begin : g_stage
            logic [DIVN_W-1:0] w_rem;
            logic [DIVD_W-1:0] w_den;
            logic [QUO_W-1:0]  w_quo;
            logic [DIVN_W-1:0] w_shd;

            if (s == 0) begin : g_first
                assign w_rem = i_num;
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[s-1];
                assign w_den = r_den[s-1];
                assign w_quo = r_quo[s-1];
            end

            // Shifted divisor for the bit this stage decides.
            assign w_shd = DIVN_W'(w_den) << (QUO_W - 1 - s);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= w_den;
                    if (w_rem >= w_shd) begin
                        r_rem[s] <= w_rem - w_shd;
                        r_quo[s] <= {w_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem[s] <= w_rem;
                        r_quo[s] <= {w_quo[QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_W-1];

endmodule

`default_nettype wire

// File: src/tvp_lane.sv
`default_nettype none

// One vertex lane: matrix transform, near and guard tests, screen and depth divides.
module tvp_lane #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int GUARD_LEFT    = -320,
    parameter int GUARD_RIGHT   = 640,
    parameter int GUARD_TOP     = -240,
    parameter int GUARD_BOTTOM  = 480
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire tvp_pkg::t_mat                      i_mat,
    input  wire logic signed [tvp_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [tvp_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic signed [tvp_pkg::COORD_W-1:0] i_pos_z,
    output tvp_pkg::t_vtx_res                       o_res
);
    import tvp_pkg::*;

    localparam logic signed [WIDE_W-1:0] K_W  = WIDE_W'(SCREEN_WIDTH);
    localparam logic signed [WIDE_W-1:0] K_H  = WIDE_W'(SCREEN_HEIGHT);
    localparam logic signed [WIDE_W-1:0] K_GL = WIDE_W'(GUARD_LEFT);
    localparam logic signed [WIDE_W-1:0] K_GR = WIDE_W'(GUARD_RIGHT);
    localparam logic signed [WIDE_W-1:0] K_GT = WIDE_W'(GUARD_TOP);
    localparam logic signed [WIDE_W-1:0] K_GB = WIDE_W'(GUARD_BOTTOM);

    // Stage 1: the twelve coefficient products.
    logic signed [WIDE_W-1:0]  r_prod [4][3];
    logic signed [COORD_W-1:0] r_tr   [4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k][0] <= WIDE_W'(signed'(i_mat[2*k][31:0]))  * WIDE_W'(i_pos_x);
                r_prod[k][1] <= WIDE_W'(signed'(i_mat[2*k][63:32])) * WIDE_W'(i_pos_y);
                r_prod[k][2] <= WIDE_W'(signed'(i_mat[2*k+1][31:0])) * WIDE_W'(i_pos_z);
                r_tr[k]      <= signed'(i_mat[2*k+1][63:32]);
            end
        end
    end

    // Stage 2: floor each product to s.16 and sum the row.
    logic signed [CLIP_W-1:0] r_clip [4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_clip[k] <= CLIP_W'(r_prod[k][0] >>> 16) + CLIP_W'(r_prod[k][1] >>> 16)
                           + CLIP_W'(r_prod[k][2] >>> 16) + CLIP_W'(r_tr[k]);
            end
        end
    end

    // Stage 3: screen numerators and guard limits scaled by 2w.
    logic signed [WIDE_W-1:0] n_d;
    logic signed [WIDE_W-1:0] r_nx, r_ny, r_nz, r_d;
    logic signed [WIDE_W-1:0] r_gl, r_gr, r_gt, r_gb;
    logic signed [CLIP_W-1:0] r_cw;

    assign n_d = WIDE_W'(r_clip[3]) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= (WIDE_W'(r_clip[0]) + WIDE_W'(r_clip[3])) * K_W;
            r_ny <= (WIDE_W'(r_clip[3]) - WIDE_W'(r_clip[1])) * K_H;
            r_nz <= WIDE_W'(r_clip[2]) + WIDE_W'(r_clip[3]);
            r_d  <= n_d;
            r_gl <= n_d * K_GL;
            r_gr <= n_d * K_GR;
            r_gt <= n_d * K_GT;
            r_gb <= n_d * K_GB;
            r_cw <= r_clip[3];
        end
    end

    // Stage 4: tests and biased dividends; screen quotients are offset by 2**15.
    t_lane_flags              n_flg;
    logic signed [DIVN_W-1:0] n_num_x, n_num_y, n_num_z;
    logic [DIVN_W-1:0]        r_num_x, r_num_y, r_num_z;
    logic [DIVD_W-1:0]        r_den;
    t_lane_flags              r_flg [QUO_W+1];

    always_comb begin
        n_flg.near    = r_cw < W_ONE;
        n_flg.guard   = (r_nx < r_gl) || (r_nx > r_gr) || (r_ny < r_gt) || (r_ny > r_gb);
        n_flg.dz_zero = r_nz <= 0;
        n_flg.dz_sat  = r_nz >= r_d;
        n_num_x = (DIVN_W'(r_nx) <<< 3) + (DIVN_W'(r_cw) <<< 15);
        n_num_y = (DIVN_W'(r_ny) <<< 3) + (DIVN_W'(r_cw) <<< 15);
        n_num_z = (n_flg.dz_zero || n_flg.dz_sat) ? '0 : (DIVN_W'(r_nz) <<< 15);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num_x  <= n_num_x;
            r_num_y  <= n_num_y;
            r_num_z  <= n_num_z;
            r_den    <= DIVD_W'(r_cw);
            r_flg[0] <= n_flg;
            for (int s = 1; s <= QUO_W; s++) begin
                r_flg[s] <= r_flg[s-1];
            end
        end
    end

    // Divider stages.
    logic [QUO_W-1:0] w_qx, w_qy, w_qz;

    tvp_div u_div_x (.i_clk(i_clk), .i_en(i_en), .i_num(r_num_x), .i_den(r_den), .o_quo(w_qx));
    tvp_div u_div_y (.i_clk(i_clk), .i_en(i_en), .i_num(r_num_y), .i_den(r_den), .o_quo(w_qy));
    tvp_div u_div_z (.i_clk(i_clk), .i_en(i_en), .i_num(r_num_z), .i_den(r_den), .o_quo(w_qz));

    // Pick the reason code, remove the bias and apply depth limits.
    always_comb begin
        if (r_flg[QUO_W].near) begin
            o_res.reason = REASON_NEAR;
        end else if (r_flg[QUO_W].guard) begin
            o_res.reason = REASON_GUARD;
        end else begin
            o_res.reason = REASON_OK;
        end
        o_res.sx = signed'({~w_qx[QUO_W-1], w_qx[QUO_W-2:0]});
        o_res.sy = signed'({~w_qy[QUO_W-1], w_qy[QUO_W-2:0]});
        if (r_flg[QUO_W].dz_zero) begin
            o_res.depth = '0;
        end else if (r_flg[QUO_W].dz_sat) begin
            o_res.depth = '1;
        end else begin
            o_res.depth = w_qz;
        end
    end

endmodule

`default_nettype wire

// File: src/triangle_vertex_projector_unit.sv
`default_nettype none

// Channel   Dir  Handshake                  Word
// s_axis    in   i_s_axis_tvalid/o_..ready  one triangle, 288-bit tdata
// m_axis    out  o_m_axis_tvalid/i_..ready  one projected triangle, 152-bit tdata
// cfg       in   i_cfg_valid/o_cfg_ready    register index and 64-bit data
//
// One triangle is accepted per cycle while the output is not stalled.
// Each vertex lane holds three 16-stage restoring dividers.
// The whole pipeline advances while the output register is empty or being taken;
// a stalled output holds every stage and drops o_s_axis_tready.
// Synchronous active-low reset loads the identity matrix and empties the pipeline.
module triangle_vertex_projector_unit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int GUARD_LEFT    = -320,
    parameter int GUARD_RIGHT   = 640,
    parameter int GUARD_TOP     = -240,
    parameter int GUARD_BOTTOM  = 480
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // a_pos_x, a_pos_y, a_pos_z, b_pos_x, .. c_pos_z, 32 bits each from bit 0 up
    input  wire logic [tvp_pkg::IN_W-1:0]        i_s_axis_tdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // reject_reason (2), a_screen_x, a_screen_y, a_depth, b_.., c_.. (16 each), zero pad
    output logic [tvp_pkg::OUT_W-1:0]            o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tvp_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [63:0]                     i_cfg_data
);
    import tvp_pkg::*;

    // Identity rows for x, y and z, and w = 1.0.
    localparam t_mat MAT_RESET = {
        64'h0001_0000_0000_0000, 64'h0,
        64'h0000_0000_0001_0000, 64'h0,
        64'h0,                   64'h0001_0000_0000_0000,
        64'h0,                   64'h0000_0000_0001_0000
    };

    // Matrix registers.
    t_mat r_mat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= MAT_RESET;
        end else if (i_cfg_valid && (i_cfg_index < REG_IDX_W'(NUM_REGS))) begin
            r_mat[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // Pipeline advance and occupancy.
    logic                r_out_valid;
    logic                w_en;
    logic [LANE_LAT-1:0] r_vld;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[LANE_LAT-2:0], i_s_axis_tvalid};
            r_out_valid <= r_vld[LANE_LAT-1];
        end
    end

    // Three vertex lanes.
    t_vtx_res w_res [3];

    genvar v;
    generate
        for (v = 0; v < 3; v++) begin : g_lane
            tvp_lane #(
                .SCREEN_WIDTH (SCREEN_WIDTH),
                .SCREEN_HEIGHT(SCREEN_HEIGHT),
                .GUARD_LEFT   (GUARD_LEFT),
                .GUARD_RIGHT  (GUARD_RIGHT),
                .GUARD_TOP    (GUARD_TOP),
                .GUARD_BOTTOM (GUARD_BOTTOM)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_mat  (r_mat),
                .i_pos_x(signed'(i_s_axis_tdata[96*v +: 32])),
                .i_pos_y(signed'(i_s_axis_tdata[96*v + 32 +: 32])),
                .i_pos_z(signed'(i_s_axis_tdata[96*v + 64 +: 32])),
                .o_res  (w_res[v])
            );
        end
    endgenerate

    // Merge: the first failing vertex sets the reason and blanks all fields.
    logic [1:0]       n_reason;
    logic [OUT_W-1:0] n_word;

    always_comb begin
        if (w_res[0].reason != REASON_OK) begin
            n_reason = w_res[0].reason;
        end else if (w_res[1].reason != REASON_OK) begin
            n_reason = w_res[1].reason;
        end else begin
            n_reason = w_res[2].reason;
        end
        n_word = '0;
        n_word[1:0] = n_reason;
        if (n_reason == REASON_OK) begin
            for (int k = 0; k < 3; k++) begin
                n_word[2 + 48*k +: 16]  = w_res[k].sx;
                n_word[18 + 48*k +: 16] = w_res[k].sy;
                n_word[34 + 48*k +: 16] = w_res[k].depth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_m_axis_tdata <= n_word;
        end
    end

    // Checks.
    a_reason_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] != 2'd3))
        else $error("reject reason out of range");

    a_reject_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[1:0] != REASON_OK)) |->
        (o_m_axis_tdata[OUT_W-1:2] == '0))
        else $error("rejected triangle carries nonzero fields");

    a_enter_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word not tracked in pipeline");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

endmodule

`default_nettype wire

// File: sim/triangle_vertex_projector_unit_tb.sv
`default_nettype none

module triangle_vertex_projector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvp_pkg::*;

    // Screen and guard band as built into the block by default.
    localparam longint SCR_W  = 320;
    localparam longint SCR_H  = 240;
    localparam longint G_LEFT = -320;
    localparam longint G_RGHT = 640;
    localparam longint G_TOP  = -240;
    localparam longint G_BOT  = 480;

    localparam int     N_RAND_PHASE  = 320;
    localparam int     N_EXTR_PHASE  = 60;
    localparam longint FIX_ONE       = 65536;
    localparam logic [15:0] CTR_SX   = 16'd2560;
    localparam logic [15:0] CTR_SY   = 16'd1920;
    localparam logic [15:0] CTR_DZ   = 16'd32768;

    // Matrix register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_XY = 8'd0, REG_X_ZT = 8'd1, REG_Y_XY = 8'd2, REG_Y_ZT = 8'd3,
        REG_Z_XY = 8'd4, REG_Z_ZT = 8'd5, REG_W_XY = 8'd6, REG_W_ZT = 8'd7
    } reg_idx_e;

    // One triangle: element 3*v+k is coordinate k of vertex v.
    typedef logic [8:0][31:0] t_tri;

    // One projected triangle, laid out as the output word.
    typedef struct packed {
        logic [5:0]       pad;
        logic [8:0][15:0] vals;   // 3*v+0 screen x, 3*v+1 screen y, 3*v+2 depth
        logic [1:0]       reason;
    } t_proj;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]        cfg_data = '0;

    logic [63:0] matrix_q [NUM_REGS];
    t_proj       proj_queue [$];
    int          mismatches = 0;
    int          src_idle = 0;
    int          snk_idle = 0;
    string       field_name [9] = '{"a_screen_x", "a_screen_y", "a_depth",
                                    "b_screen_x", "b_screen_y", "b_depth",
                                    "c_screen_x", "c_screen_y", "c_depth"};

    triangle_vertex_projector_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sext32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // Floor of n * 16^steps / d for d > 0.
    function automatic longint floor_div_hex(longint n, longint d, int steps);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r < 0) begin
            q -= 1;
            r += d;
        end
        for (int i = 0; i < steps; i++) begin
            r *= 16;
            q = q * 16 + r / d;
            r %= d;
        end
        return q;
    endfunction

    function automatic logic [15:0] sat_s16(longint v);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    // One clip component: each product floored to .16 before the sum.
    function automatic longint clip_comp(int k, longint px, longint py, longint pz);
        logic [63:0] xy;
        logic [63:0] zt;
        xy = matrix_q[2 * k];
        zt = matrix_q[2 * k + 1];
        return ((sext32(xy[31:0]) * px) >>> 16) + ((sext32(xy[63:32]) * py) >>> 16) +
               ((sext32(zt[31:0]) * pz) >>> 16) + sext32(zt[63:32]);
    endfunction

    // Projects one vertex; screen fields are only written when it passes.
    function automatic logic [1:0] project_vertex(input logic [31:0] ox, oy, oz,
                                                  output logic [15:0] sx, sy, dz);
        longint px, py, pz, cx, cy, cz, cw, d, nx, ny, nz, depth;
        px = sext32(ox);
        py = sext32(oy);
        pz = sext32(oz);
        cx = clip_comp(0, px, py, pz);
        cy = clip_comp(1, px, py, pz);
        cz = clip_comp(2, px, py, pz);
        cw = clip_comp(3, px, py, pz);
        sx = '0;
        sy = '0;
        dz = '0;
        if (cw < FIX_ONE) return REASON_NEAR;
        d  = 2 * cw;
        nx = SCR_W * (cx + cw);
        ny = SCR_H * (cw - cy);
        if (nx < G_LEFT * d || nx > G_RGHT * d || ny < G_TOP * d || ny > G_BOT * d)
            return REASON_GUARD;
        sx = sat_s16(floor_div_hex(nx, d, 1));
        sy = sat_s16(floor_div_hex(ny, d, 1));
        nz = cz + cw;
        if (nz <= 0) depth = 0;
        else if (nz >= d) depth = 65535;
        else begin
            depth = floor_div_hex(nz, d, 4);
            if (depth > 65535) depth = 65535;
        end
        dz = depth[15:0];
        return REASON_OK;
    endfunction

    // Whole triangle; a rejected one carries zeros in every vertex field.
    function automatic t_proj project_triangle(t_tri t);
        t_proj r;
        logic [1:0] why;
        r = '0;
        why = REASON_OK;
        for (int v = 0; v < 3 && why == REASON_OK; v++)
            why = project_vertex(t[3*v], t[3*v+1], t[3*v+2],
                                 r.vals[3*v], r.vals[3*v+1], r.vals[3*v+2]);
        if (why != REASON_OK) r = '0;
        r.reason = why;
        return r;
    endfunction

    function automatic t_proj centered_proj();
        t_proj r;
        r = '0;
        for (int v = 0; v < 3; v++) begin
            r.vals[3*v]   = CTR_SX;
            r.vals[3*v+1] = CTR_SY;
            r.vals[3*v+2] = CTR_DZ;
        end
        return r;
    endfunction

    function automatic t_proj rejected(logic [1:0] why);
        t_proj r;
        r = '0;
        r.reason = why;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) return 32'($urandom_range(0, 262144)) - 32'd131072;
        if (pick < 95) return $urandom;
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            default: return 32'h0;
        endcase
    endfunction

    // Signed s15.16 coefficient in [-span, span] units of 1/65536.
    function automatic logic [31:0] rand_coef(int unsigned span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // Register write on the configuration channel.
    task automatic write_reg(reg_idx_e idx, logic [63:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        matrix_q[idx] = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random perspective-like matrix; translation of w may drop below 1.0.
    task automatic load_projection();
        reg_idx_e r;
        r = r.first();
        repeat (NUM_REGS) begin
            if (r == REG_W_XY)
                write_reg(r, {rand_coef(16384), rand_coef(16384)});
            else if (r == REG_W_ZT)
                write_reg(r, {32'($urandom_range(0, 8 * 65536)), rand_coef(65536)});
            else
                write_reg(r, {rand_coef(131072), rand_coef(131072)});
            r = r.next();
        end
    endtask

    task automatic load_uniform(logic [63:0] val);
        reg_idx_e r;
        r = r.first();
        repeat (NUM_REGS) begin
            write_reg(r, val);
            r = r.next();
        end
    endtask

    // Sends one triangle word, idling at random before it.
    task automatic send_triangle(t_tri t, logic typed, t_proj want);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = t;
        do @(posedge clk); while (!s_tready);
        proj_queue.push_back(typed ? want : project_triangle(t));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (proj_queue.size() != 0) @(negedge clk);
        repeat (LANE_LAT + 4) @(negedge clk);
    endtask

    task automatic directed_rows();
        t_tri  t;
        t_proj p;
        // Centered triangle under the identity matrix.
        send_triangle('0, 1'b1, centered_proj());
        t = '0; t[0] = 32'h7FFF_FFFF;
        send_triangle(t, 1'b1, rejected(REASON_GUARD));
        t = '0; t[4] = 32'h8000_0000;
        send_triangle(t, 1'b1, rejected(REASON_GUARD));
        // Depth saturates at the top, clamps to zero at the bottom and scales linearly in between.
        t = '0; t[8] = 32'h7FFF_FFFF; p = centered_proj(); p.vals[8] = 16'hFFFF;
        send_triangle(t, 1'b1, p);
        t = '0; t[2] = 32'h8000_0000; p = centered_proj(); p.vals[2] = 16'h0;
        send_triangle(t, 1'b1, p);
        t = '0; t[2] = 32'hFFFF_0000; p = centered_proj(); p.vals[2] = 16'h0;
        send_triangle(t, 1'b1, p);
        t = '0; t[5] = 32'h0000_FFFF; p = centered_proj(); p.vals[5] = 16'hFFFF;
        send_triangle(t, 1'b1, p);
        t = '0; t[8] = 32'h0000_8000; p = centered_proj(); p.vals[8] = 16'd49152;
        send_triangle(t, 1'b1, p);
        // Vertices exactly on each guard edge still pass.
        t = '0; t[0] = 32'd196608; p = centered_proj(); p.vals[0] = 16'd10240;
        send_triangle(t, 1'b1, p);
        t = '0; t[3] = -32'sd196608; p = centered_proj(); p.vals[3] = -16'sd5120;
        send_triangle(t, 1'b1, p);
        t = '0; t[7] = -32'sd196608; p = centered_proj(); p.vals[7] = 16'd7680;
        send_triangle(t, 1'b1, p);
        t = '0; t[1] = 32'd196608; p = centered_proj(); p.vals[1] = -16'sd3840;
        send_triangle(t, 1'b1, p);
        // Just past the right edge.
        t = '0; t[0] = 32'd196609;
        send_triangle(t, 1'b1, rejected(REASON_GUARD));
        // Two good vertices, then a bad third one clears everything.
        t = '0; t[7] = 32'h8000_0000;
        send_triangle(t, 1'b1, rejected(REASON_GUARD));
        // Rounding toward minus infinity on small offsets, then all-ones and extreme coordinates.
        t = '0; t[0] = 32'h1;
        send_triangle(t, 1'b0, '0);
        t = '0; t[0] = 32'hFFFF_FFFF; t[4] = 32'h1;
        send_triangle(t, 1'b0, '0);
        send_triangle('1, 1'b0, '0);
        t = {9{32'h8000_0000}};
        send_triangle(t, 1'b0, '0);
        t = {9{32'h7FFF_FFFF}};
        send_triangle(t, 1'b0, '0);
    endtask

    // Receiver readiness.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    // Result check against the oldest waiting expectation.
    always @(posedge clk) begin
        t_proj got;
        t_proj want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (proj_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word at %0t: %h", $realtime, m_tdata);
            end else begin
                want = proj_queue.pop_front();
                if (got.reason !== want.reason) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reject_reason: expected %0d, got %0d",
                                 want.reason, got.reason);
                end
                for (int k = 0; k < 9; k++) begin
                    if (got.vals[k] !== want.vals[k]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s: expected %h, got %h", field_name[k],
                                     want.vals[k], got.vals[k]);
                    end
                end
                if (got.pad !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pad bits: expected 0, got %h", got.pad);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int n;
        matrix_q[REG_X_XY] = 64'h0000_0000_0001_0000;
        matrix_q[REG_X_ZT] = 64'h0;
        matrix_q[REG_Y_XY] = 64'h0001_0000_0000_0000;
        matrix_q[REG_Y_ZT] = 64'h0;
        matrix_q[REG_Z_XY] = 64'h0;
        matrix_q[REG_Z_ZT] = 64'h0000_0000_0001_0000;
        matrix_q[REG_W_XY] = 64'h0;
        matrix_q[REG_W_ZT] = 64'h0001_0000_0000_0000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Three idling modes, three matrix settings in each.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin src_idle = 38; snk_idle = 58; end
                1: begin src_idle = 58; snk_idle = 38; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            n = N_RAND_PHASE;
            if (ph == 0) begin
                directed_rows();
            end else if (ph % 3 == 2) begin
                case (ph)
                    2: load_uniform(64'h7FFF_FFFF_7FFF_FFFF);
                    5: load_uniform(64'h8000_0000_8000_0000);
                    default: load_uniform('1);
                endcase
                n = N_EXTR_PHASE;
            end else begin
                load_projection();
            end
            for (int i = 0; i < n; i++)
                send_triangle({rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord()}, 1'b0, '0);
            drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/tvp_pkg.sv
src/tvp_div.sv
src/tvp_lane.sv
src/triangle_vertex_projector_unit.sv
sim/triangle_vertex_projector_unit_tb.sv
